>>> hw/rtl/kcm_pkg.sv
// ----------------------------------------------------------------------------
// kcm_pkg
// Shared constants, types and codes of the Kruskal component merger.
// ----------------------------------------------------------------------------
package kcm_pkg;

  // Vertex store depth and field widths
  localparam int MAX_VERTICES = 256;
  localparam int EDGE_W       = 8;
  localparam int CNT_W        = 8;
  localparam int SZW          = 9;

  // Label width: enough bits for any vertex index below MAX_VERTICES
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // Cell chain geometry: each cell holds LANES vertices
  localparam int LANES  = (MAX_VERTICES >= 8) ? 8 : (1 << VW);
  localparam int LW     = $clog2(LANES);
  localparam int NCELLS = (MAX_VERTICES + LANES - 1) / LANES;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int IDXW   = CW + LW;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input command codes
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic {
    TOK_LOOKUP,
    TOK_RELABEL
  } tok_phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_RELABEL,
    S_RESULT
  } ctrl_state_t;

  // Token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic             valid;
    tok_phase_t       phase;
    logic [VW-1:0]    u;      // lookup: endpoints to find
    logic [VW-1:0]    v;
    logic [VW-1:0]    la;     // lookup: gathered labels and sizes
    logic [VW-1:0]    lb;
    logic [SZW-1:0]   sa;
    logic [SZW-1:0]   sb;
    logic [VW-1:0]    keep;   // relabel: surviving label
    logic [VW-1:0]    gone;   // relabel: absorbed label
    logic [SZW-1:0]   sum;    // relabel: merged component size
  } token_t;

endpackage

>>> hw/rtl/kcm_in_if.sv
// ----------------------------------------------------------------------------
// kcm_in_if
// Edge/command input channel: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface kcm_in_if;
  import kcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [EDGE_W-1:0] edge_u;
  logic [EDGE_W-1:0] edge_v;
  logic              last_edge;

  modport source (output valid, cmd, edge_u, edge_v, last_edge, input ready);
  modport sink   (input valid, cmd, edge_u, edge_v, last_edge, output ready);
endinterface

>>> hw/rtl/kcm_out_if.sv
// ----------------------------------------------------------------------------
// kcm_out_if
// Result channel: valid/ready handshake with the per-edge result item.
// ----------------------------------------------------------------------------
interface kcm_out_if;
  import kcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [EDGE_W-1:0] tree_u;
  logic [EDGE_W-1:0] tree_v;
  logic [CNT_W-1:0]  tree_edges;
  logic              list_done;

  modport source (output valid, accepted, tree_u, tree_v, tree_edges, list_done,
                  input ready);
  modport sink   (input valid, accepted, tree_u, tree_v, tree_edges, list_done,
                  output ready);
endinterface

>>> hw/rtl/kruskal_component_merger.sv
// ----------------------------------------------------------------------------
// kruskal_component_merger
// Component merging core of Kruskal's MST with union by size.
// ----------------------------------------------------------------------------
// Edges come in already sorted by weight, one item at a time; each gives one
// result item. Vertex labels and component sizes live in a chain of NCELLS
// cells (32 for 256 vertices, 8 vertices per cell), and a token walks that
// chain one cell per clock. Every in-range edge costs one lookup pass down
// the chain; an edge that joins two components costs a second, relabel
// pass. Edges with an endpoint at or above MAX_VERTICES are rejected
// without a pass.
// One item is in work at a time; the registered result may wait for the
// sink without holding up the chain work of the next item.
module kruskal_component_merger (
  input logic       clk,
  input logic       rst_n,
  kcm_in_if.sink    in_ch,
  kcm_out_if.source out_ch
);
  import kcm_pkg::*;

  token_t            chain [NCELLS+1];
  logic [NCELLS-1:0] tok_valid_vec;
  logic              clear;

  kcm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .tok_o  (chain[0]),
    .tok_i  (chain[NCELLS]),
    .clear  (clear)
  );

  // Vertex cell chain
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    kcm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (clear),
      .cell_idx (CW'(k)),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1])
    );
    assign tok_valid_vec[k] = chain[k+1].valid;
  end

  // At most one token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid_vec) <= 1)
    else $error("more than one token in the cell chain");

  // Clear never overlaps a pass in flight
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clear |-> (tok_valid_vec == '0))
    else $error("clear while a token is in the chain");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accept");

  // A tree edge always shows a nonzero edge count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted) |-> (out_ch.tree_edges != '0))
    else $error("accepted edge with zero tree edge count");

endmodule

>>> hw/rtl/kcm_cell.sv
// ----------------------------------------------------------------------------
// kcm_cell
// One link of the vertex chain: holds label and component size of LANES
// vertices, answers lookups and applies relabels as the token passes.
// ----------------------------------------------------------------------------
module kcm_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic [kcm_pkg::CW-1:0] cell_idx,
  input  kcm_pkg::token_t        tok_i,
  output kcm_pkg::token_t        tok_o
);
  import kcm_pkg::*;

  logic [VW-1:0]   label_r   [LANES];
  logic [VW-1:0]   label_nxt [LANES];
  logic [SZW-1:0]  size_r    [LANES];
  logic [SZW-1:0]  size_nxt  [LANES];
  logic [IDXW-1:0] lane_idx  [LANES];
  token_t          tok_r;
  token_t          tok_nxt;

  // Vertex index of each lane
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lane_idx[j] = {cell_idx, LW'(j)};
    end
  end

  // Lookup: drop label and size of matching endpoints into the token
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && tok_i.phase == TOK_LOOKUP) begin
      for (int j = 0; j < LANES; j++) begin
        if (IDXW'(tok_i.u) == lane_idx[j]) begin
          tok_nxt.la = label_r[j];
          tok_nxt.sa = size_r[j];
        end
        if (IDXW'(tok_i.v) == lane_idx[j]) begin
          tok_nxt.lb = label_r[j];
          tok_nxt.sb = size_r[j];
        end
      end
    end
  end

  // Relabel: members of both merged components take the keeper label
  // and the merged size; clear restores the initial partition
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      label_nxt[j] = label_r[j];
      size_nxt[j]  = size_r[j];
      if (clear) begin
        label_nxt[j] = VW'(lane_idx[j]);
        size_nxt[j]  = SZW'(1);
      end else if (tok_i.valid && tok_i.phase == TOK_RELABEL &&
                   (label_r[j] == tok_i.gone || label_r[j] == tok_i.keep)) begin
        label_nxt[j] = tok_i.keep;
        size_nxt[j]  = tok_i.sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      for (int j = 0; j < LANES; j++) begin
        label_r[j] <= VW'(lane_idx[j]);
        size_r[j]  <= SZW'(1);
      end
    end else begin
      tok_r <= tok_nxt;
      for (int j = 0; j < LANES; j++) begin
        label_r[j] <= label_nxt[j];
        size_r[j]  <= size_nxt[j];
      end
    end
  end

  assign tok_o = tok_r;

endmodule

>>> hw/rtl/kcm_ctrl.sv
// ----------------------------------------------------------------------------
// kcm_ctrl
// Sequencer: takes an item, sends a lookup token down the cell chain,
// decides the merge, sends a relabel token, and registers the result.
// ----------------------------------------------------------------------------
module kcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  kcm_in_if.sink          in_ch,
  kcm_out_if.source       out_ch,
  output kcm_pkg::token_t tok_o,
  input  kcm_pkg::token_t tok_i,
  output logic            clear
);
  import kcm_pkg::*;

  ctrl_state_t       state_r;
  ctrl_state_t       state_nxt;
  logic              accept;
  logic              in_range;
  logic              differ;
  logic              load_out;
  logic [SZW:0]      sum_full;
  logic [EDGE_W-1:0] u_r;
  logic [EDGE_W-1:0] v_r;
  logic              last_r;
  logic              acc_r;
  logic [CNT_W-1:0]  count_r;
  logic              out_valid_r;
  logic              out_acc_r;
  logic [EDGE_W-1:0] out_u_r;
  logic [EDGE_W-1:0] out_v_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = (32'(in_ch.edge_u) < MAX_VERTICES) &&
                       (32'(in_ch.edge_v) < MAX_VERTICES);
  assign differ      = (tok_i.la != tok_i.lb);
  assign sum_full    = {1'b0, tok_i.sa} + {1'b0, tok_i.sb};
  assign load_out    = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_EDGE && in_range) state_nxt = S_LOOKUP;
          else                                   state_nxt = S_RESULT;
        end
      end
      S_LOOKUP: begin
        if (tok_i.valid) state_nxt = differ ? S_RELABEL : S_RESULT;
      end
      S_RELABEL: begin
        if (tok_i.valid) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Token launch and clear strobe
  always_comb begin
    tok_o       = '0;
    tok_o.phase = TOK_LOOKUP;
    clear       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_ch.cmd == CMD_CLEAR) begin
          clear = 1'b1;
        end else if (accept && in_range) begin
          tok_o.valid = 1'b1;
          tok_o.u     = VW'(in_ch.edge_u);
          tok_o.v     = VW'(in_ch.edge_v);
        end
      end
      S_LOOKUP: begin
        if (tok_i.valid && differ) begin
          tok_o.valid = 1'b1;
          tok_o.phase = TOK_RELABEL;
          tok_o.sum   = sum_full[SZW-1:0];
          // union by size: first side survives only if strictly larger
          if (tok_i.sa > tok_i.sb) begin
            tok_o.keep = tok_i.la;
            tok_o.gone = tok_i.lb;
          end else begin
            tok_o.keep = tok_i.lb;
            tok_o.gone = tok_i.la;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state, edge count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clear) begin
        count_r <= '0;
      end else if (state_r == S_LOOKUP && tok_i.valid && differ &&
                   count_r != CNT_MAX) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Item payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      u_r    <= in_ch.edge_u;
      v_r    <= in_ch.edge_v;
      last_r <= in_ch.last_edge;
      acc_r  <= 1'b0;
    end else if (state_r == S_LOOKUP && tok_i.valid && differ) begin
      acc_r  <= 1'b1;
    end
    if (load_out) begin
      out_acc_r  <= acc_r;
      out_u_r    <= u_r;
      out_v_r    <= v_r;
      out_cnt_r  <= count_r;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.tree_u     = out_u_r;
  assign out_ch.tree_v     = out_v_r;
  assign out_ch.tree_edges = out_cnt_r;
  assign out_ch.list_done  = out_last_r;

endmodule
